[hw/rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, constants and types of the ray and wall segment intersection
// block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int CW    = 24;          // coordinate width, Q15.8
    localparam int DW    = 16;          // direction width, Q1.14
    localparam int FRAC  = 8;           // fractional bits of a coordinate
    localparam int DFRAC = 14;          // fractional bits of a direction
    localparam int EW    = CW + 1;      // coordinate differences
    localparam int PD_W  = EW + DW;     // difference times direction
    localparam int DEN_W = PD_W + 1;    // denominator and t numerator
    localparam int PU_W  = 2 * EW;      // difference times difference
    localparam int UN_W  = PU_W + 1;    // u numerator
    localparam int AD_W  = DEN_W - 1;   // magnitude of the denominator
    localparam int M_W   = UN_W;        // magnitude of the u numerator
    localparam int K_W   = DW;          // magnitude of a direction component
    localparam int ML_W  = (M_W + 1) / 2;
    localparam int MH_W  = M_W - ML_W;
    localparam int P_W   = M_W + K_W;   // dividend
    localparam int QW    = CW + 1;      // quotient bits kept before clamping
    localparam int DIV_LAT = QW + 1;    // overflow check plus one step per bit
    localparam int SUM_W = CW + 2;
    localparam int Q_DEPTH = 4;
    localparam int QA_W  = $clog2(Q_DEPTH);
    localparam int QC_W  = QA_W + 1;

    localparam logic [QW-1:0]          Q_CAP      = QW'(1) << CW;
    localparam logic signed [CW-1:0]   MISS_COORD = CW'(-(2 ** FRAC));
    localparam logic signed [SUM_W-1:0] S_MAX     = SUM_W'((2 ** (CW - 1)) - 1);
    localparam logic signed [SUM_W-1:0] S_MIN     = SUM_W'(-(2 ** (CW - 1)));
    localparam logic signed [DW-1:0]   RST_DIR_X  = DW'(2 ** DFRAC);

    typedef enum logic [1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_DIR_X    = 2'd2,
        CFG_DIR_Y    = 2'd3
    } t_cfg_idx;

    // One classified segment on its way from the front to the back.
    typedef struct packed {
        logic            hit;
        logic [M_W-1:0]  m;
        logic [AD_W-1:0] den;
    } t_job;

endpackage

[hw/rtl/rsi_seg_if.sv]
// ----------------------------------------------------------------------------
// rsi_seg_if
// Channel carrying one wall segment per transfer.
// ----------------------------------------------------------------------------
interface rsi_seg_if import rsi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] seg_ax;
    logic signed [CW-1:0] seg_ay;
    logic signed [CW-1:0] seg_bx;
    logic signed [CW-1:0] seg_by;

    modport source (output valid, seg_ax, seg_ay, seg_bx, seg_by, input ready);
    modport sink   (input valid, seg_ax, seg_ay, seg_bx, seg_by, output ready);
endinterface

[hw/rtl/rsi_hit_if.sv]
// ----------------------------------------------------------------------------
// rsi_hit_if
// Channel carrying one intersection result per transfer.
// ----------------------------------------------------------------------------
interface rsi_hit_if import rsi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;

    modport source (output valid, hit, hit_x, hit_y, input ready);
    modport sink   (input valid, hit, hit_x, hit_y, output ready);
endinterface

[hw/rtl/rsi_front.sv]
// ----------------------------------------------------------------------------
// rsi_front
// Takes segments in, forms the cross products and classifies hit or miss.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rsi_seg_if.sink              i_seg,
    input  logic signed [CW-1:0] i_org_x,
    input  logic signed [CW-1:0] i_org_y,
    input  logic signed [DW-1:0] i_dir_x,
    input  logic signed [DW-1:0] i_dir_y,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [EW-1:0]    r_ex, r_ey, r_fx, r_fy;
    logic signed [PD_W-1:0]  r_eydx, r_exdy, r_fydx, r_fxdy;
    logic signed [PU_W-1:0]  r_exfy, r_eyfx;
    logic signed [DEN_W-1:0] r_den, r_tn, r_den_a, r_tn_n;
    logic signed [UN_W-1:0]  r_un, r_un_n;

    // The whole front moves together; it holds only when its last stage
    // cannot hand its segment to the queue.
    assign en          = !(r_v4 && i_q_full);
    assign i_seg.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_seg.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex <= EW'(i_seg.seg_ax) - EW'(i_seg.seg_bx);
            r_ey <= EW'(i_seg.seg_ay) - EW'(i_seg.seg_by);
            r_fx <= EW'(i_seg.seg_ax) - EW'(i_org_x);
            r_fy <= EW'(i_seg.seg_ay) - EW'(i_org_y);

            r_eydx <= r_ey * i_dir_x;
            r_exdy <= r_ex * i_dir_y;
            r_fydx <= r_fy * i_dir_x;
            r_fxdy <= r_fx * i_dir_y;
            r_exfy <= r_ex * r_fy;
            r_eyfx <= r_ey * r_fx;

            r_den <= DEN_W'(r_eydx) - DEN_W'(r_exdy);
            r_tn  <= DEN_W'(r_fydx) - DEN_W'(r_fxdy);
            r_un  <= UN_W'(r_exfy) - UN_W'(r_eyfx);

            // Fold the sign of the denominator into both numerators.
            r_den_a <= r_den[DEN_W-1] ? -r_den : r_den;
            r_tn_n  <= r_den[DEN_W-1] ? -r_tn  : r_tn;
            r_un_n  <= r_den[DEN_W-1] ? -r_un  : r_un;
        end
    end

    logic signed [UN_W-1:0] neg_un;
    assign neg_un = -r_un_n;

    assign o_push      = r_v4 && !i_q_full;
    assign o_job.hit   = (r_den_a != '0) && (r_tn_n > 0) && (r_tn_n < r_den_a)
                         && r_un_n[UN_W-1];
    assign o_job.m     = M_W'(neg_un);
    assign o_job.den   = r_den_a[AD_W-1:0];

endmodule

[hw/rtl/rsi_queue.sv]
// ----------------------------------------------------------------------------
// rsi_queue
// Short queue of classified segments between the front and the back.
// ----------------------------------------------------------------------------
module rsi_queue import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job             r_mem [Q_DEPTH];
    logic [QA_W-1:0]  r_wr, r_rd;
    logic [QC_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QC_W'(i_push) - QC_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(Q_DEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/rsi_div.sv]
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider, one quotient bit per stage, clamped quotient.
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [P_W-1:0]  i_num,
    input  logic [AD_W-1:0] i_den,
    output logic [QW-1:0]   o_q
);

    logic [P_W-1:0]  r_rem [DIV_LAT];
    logic [AD_W-1:0] r_dv  [DIV_LAT];
    logic [QW-1:0]   r_q   [DIV_LAT];
    logic            r_ov  [DIV_LAT];

    // First stage only notes whether the quotient needs more bits than kept.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_dv[0]  <= i_den;
            r_q[0]   <= '0;
            r_ov[0]  <= i_num >= P_W'({i_den, QW'(0)});
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
        logic [P_W-1:0] sh;
        assign sh = P_W'(r_dv[j-1]) << (QW - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j] <= r_dv[j-1];
                r_ov[j] <= r_ov[j-1];
                if (r_rem[j-1] >= sh) begin
                    r_rem[j] <= r_rem[j-1] - sh;
                    r_q[j]   <= r_q[j-1] | (QW'(1) << (QW - j));
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_q[j]   <= r_q[j-1];
                end
            end
        end
    end

    assign o_q = (r_ov[DIV_LAT-1] || r_q[DIV_LAT-1] > Q_CAP) ? Q_CAP : r_q[DIV_LAT-1];

endmodule

[hw/rtl/rsi_back.sv]
// ----------------------------------------------------------------------------
// rsi_back
// Scales the ray offset, divides by the denominator and places the hit point.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_job                 i_job,
    output logic                 o_pop,
    input  logic signed [CW-1:0] i_org_x,
    input  logic signed [CW-1:0] i_org_y,
    input  logic signed [DW-1:0] i_dir_x,
    input  logic signed [DW-1:0] i_dir_y,
    rsi_hit_if.source            o_hit
);

    logic en;
    logic [K_W-1:0] kx, ky;
    logic r_v0, r_v1, r_v2, r_out_v;
    logic r_h0, r_h1, r_h2;
    logic r_dvv [DIV_LAT];
    logic r_dvh [DIV_LAT];
    logic [M_W-1:0]  r_m;
    logic [AD_W-1:0] r_den0, r_den1, r_den2;
    logic [ML_W+K_W-1:0] r_lx, r_ly;
    logic [MH_W+K_W-1:0] r_hx, r_hy;
    logic [P_W-1:0]  r_px, r_py;
    logic [QW-1:0]   qx, qy;
    logic signed [SUM_W-1:0] sx, sy;
    logic r_hit;
    logic signed [CW-1:0] r_x, r_y;

    function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [CW-1:0] r;
        if (v > S_MAX)      r = S_MAX[CW-1:0];
        else if (v < S_MIN) r = S_MIN[CW-1:0];
        else                r = v[CW-1:0];
        return r;
    endfunction

    assign en    = !r_out_v || o_hit.ready;
    assign o_pop = en && !i_q_empty;

    assign kx = i_dir_x[DW-1] ? K_W'(-i_dir_x) : K_W'(i_dir_x);
    assign ky = i_dir_y[DW-1] ? K_W'(-i_dir_y) : K_W'(i_dir_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) r_dvv[i] <= 1'b0;
        end else if (en) begin
            r_v0     <= !i_q_empty;
            r_v1     <= r_v0;
            r_v2     <= r_v1;
            r_dvv[0] <= r_v2;
            for (int i = 1; i < DIV_LAT; i++) r_dvv[i] <= r_dvv[i-1];
            r_out_v  <= r_dvv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h0   <= i_job.hit;
            r_m    <= i_job.m;
            r_den0 <= i_job.den;

            r_h1   <= r_h0;
            r_den1 <= r_den0;
            r_lx   <= r_m[ML_W-1:0] * kx;
            r_hx   <= r_m[M_W-1:ML_W] * kx;
            r_ly   <= r_m[ML_W-1:0] * ky;
            r_hy   <= r_m[M_W-1:ML_W] * ky;

            r_h2   <= r_h1;
            r_den2 <= r_den1;
            r_px   <= (P_W'(r_hx) << ML_W) + P_W'(r_lx);
            r_py   <= (P_W'(r_hy) << ML_W) + P_W'(r_ly);

            r_dvh[0] <= r_h2;
            for (int i = 1; i < DIV_LAT; i++) r_dvh[i] <= r_dvh[i-1];

            r_hit <= r_dvh[DIV_LAT-1];
            r_x   <= r_dvh[DIV_LAT-1] ? sat(sx) : MISS_COORD;
            r_y   <= r_dvh[DIV_LAT-1] ? sat(sy) : MISS_COORD;
        end
    end

    rsi_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r_px), .i_den(r_den2), .o_q(qx));
    rsi_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r_py), .i_den(r_den2), .o_q(qy));

    assign sx = i_dir_x[DW-1] ? SUM_W'(i_org_x) - SUM_W'(qx) : SUM_W'(i_org_x) + SUM_W'(qx);
    assign sy = i_dir_y[DW-1] ? SUM_W'(i_org_y) - SUM_W'(qy) : SUM_W'(i_org_y) + SUM_W'(qy);

    assign o_hit.valid = r_out_v;
    assign o_hit.hit   = r_hit;
    assign o_hit.hit_x = r_x;
    assign o_hit.hit_y = r_y;

endmodule

[hw/rtl/ray_segment_intersection.sv]
// ----------------------------------------------------------------------------
// ray_segment_intersection
// Tests one wall segment per transfer against a configured ray and returns
// hit or miss with the saturated intersection point.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Payload
//  i_seg     in   valid / ready    seg_ax, seg_ay, seg_bx, seg_by (Q15.8)
//  o_hit     out  valid / ready    hit, hit_x, hit_y (Q15.8)
//  i_cfg_*   in   write enable     index, data (origin Q15.8, direction Q1.14)
//
// One segment is taken per cycle and one result leaves per cycle when the
// output is not stalled. A segment passes the register stages of the front,
// the queue, and in the back the scaling stages, the divider's quotient
// pipeline with one bit per stage and the output register.
// Reset is synchronous and active low; it empties every stage and the queue
// and loads the default ray (origin zero, direction along +x).
// A stall on the output holds the back; the four-entry queue keeps absorbing
// segments until it fills, and only then is i_seg.ready withdrawn.
// ----------------------------------------------------------------------------
module ray_segment_intersection import rsi_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_data,
    rsi_seg_if.sink         i_seg,
    rsi_hit_if.source       o_hit
);

    logic signed [CW-1:0] r_org_x, r_org_y;
    logic signed [DW-1:0] r_dir_x, r_dir_y;
    logic q_push, q_pop, q_full, q_empty;
    t_job push_job, head_job;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_dir_x <= RST_DIR_X;
            r_dir_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_DIR_X:    r_dir_x <= i_cfg_data[DW-1:0];
                CFG_DIR_Y:    r_dir_y <= i_cfg_data[DW-1:0];
                default:      ;
            endcase
        end
    end

    // Front: differences, cross products and the hit test.
    rsi_front u_front (
        .i_clk, .i_rst_n, .i_seg,
        .i_org_x(r_org_x), .i_org_y(r_org_y),
        .i_dir_x(r_dir_x), .i_dir_y(r_dir_y),
        .i_q_full(q_full), .o_push(q_push), .o_job(push_job)
    );

    // The queue lets a stalled output leave the front running for a while.
    rsi_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(q_push), .i_job(push_job),
        .i_pop(q_pop), .o_full(q_full), .o_empty(q_empty), .o_job(head_job)
    );

    // Back: scaling of the offset, division per axis and placement.
    rsi_back u_back (
        .i_clk, .i_rst_n,
        .i_q_empty(q_empty), .i_job(head_job), .o_pop(q_pop),
        .i_org_x(r_org_x), .i_org_y(r_org_y),
        .i_dir_x(r_dir_x), .i_dir_y(r_dir_y),
        .o_hit
    );

    // A miss always reports minus one in both coordinates.
    a_miss_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit.valid && !o_hit.hit) |->
            (o_hit.hit_x == MISS_COORD && o_hit.hit_y == MISS_COORD))
        else $error("miss without the miss coordinates");

    // A result that waits for the receiver stays offered and unchanged.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit.valid && !o_hit.ready) |=>
            (o_hit.valid && $stable(o_hit.hit) && $stable(o_hit.hit_x)
             && $stable(o_hit.hit_y)))
        else $error("result changed while waiting");

    // The result valid is always a known level once out of reset.
    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_hit.valid))
        else $error("result valid unknown");

endmodule

[verif/rsi_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsi_tb_if
// Testbench item types for the segment and result channels; the RTL interfaces are
// reused directly, so this file only holds the shared item types.
// ----------------------------------------------------------------------------
package rsi_tb_pkg;
    import rsi_pkg::*;

    typedef struct {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
    } t_wall;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_strike;
endpackage

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray and wall segment intersection block.
// ----------------------------------------------------------------------------
// Walls are fed through the segment channel with random gaps. Each accepted
// transfer is run through an exact integer model of the ray test, and the
// predicted strike is queued. Every result transfer is checked against the
// oldest queued strike. The ray is reprogrammed between phases, only while
// the block is empty.
// ----------------------------------------------------------------------------
module tb;
    import rsi_pkg::*;
    import rsi_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [CW-1:0] i_cfg_data = '0;

    rsi_seg_if seg_ch ();
    rsi_hit_if hit_ch ();

    ray_segment_intersection DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_seg      (seg_ch.sink),
        .o_hit      (hit_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // The bench's own copy of the ray.
    logic signed [CW-1:0] ray_ox, ray_oy;
    logic signed [DW-1:0] ray_dx, ray_dy;

    t_strike strikes_due[$];
    int      errors = 0;
    bit      rx_hold = 1'b0;     // set to force a long stall on the output
    bit      rx_quiet = 1'b0;    // set for stretches without output idling
    bit      tx_quiet = 1'b0;

    initial begin
        seg_ch.valid = 1'b0;
        seg_ch.seg_ax = '0;
        seg_ch.seg_ay = '0;
        seg_ch.seg_bx = '0;
        seg_ch.seg_by = '0;
        hit_ch.ready = 1'b0;
    end

    // Offset along one axis: sign(k) * trunc(m*|k| / den), clamped at 1 << CW,
    // then added to the origin with saturation onto the range of a coordinate.
    function automatic logic signed [CW-1:0] place_axis(
        input logic signed [CW-1:0] org, input logic [127:0] m,
        input logic signed [DW-1:0] k, input logic [127:0] den);
        logic [127:0] kmag, q;
        longint v;
        kmag = (k < 0) ? 128'(-longint'(k)) : 128'(k);
        q = (m * kmag) / den;
        if (q > (128'd1 << CW)) q = 128'd1 << CW;
        v = (k < 0) ? longint'(org) - longint'(q[63:0]) : longint'(org) + longint'(q[63:0]);
        if (v > (longint'(1) << (CW - 1)) - 1) v = (longint'(1) << (CW - 1)) - 1;
        if (v < -(longint'(1) << (CW - 1))) v = -(longint'(1) << (CW - 1));
        return v[CW-1:0];
    endfunction

    // Exact ray against wall test: denominator, t numerator and u numerator
    // are formed in wide signed arithmetic so nothing wraps.
    function automatic t_strike predict_strike(input t_wall w);
        t_strike s;
        logic signed [127:0] ex, ey, fx, fy, dx, dy, den, tn, un;
        ex = w.ax - w.bx; ey = w.ay - w.by;
        fx = 128'(w.ax) - 128'(ray_ox);
        fy = 128'(w.ay) - 128'(ray_oy);
        ex = 128'(w.ax) - 128'(w.bx);
        ey = 128'(w.ay) - 128'(w.by);
        dx = ray_dx; dy = ray_dy;
        den = ey * dx - ex * dy;
        tn = fy * dx - fx * dy;
        un = ex * fy - ey * fx;
        if (den < 0) begin
            den = -den; tn = -tn; un = -un;
        end
        if (den != 0 && tn > 0 && tn < den && un < 0) begin
            s.hit = 1'b1;
            s.x = place_axis(ray_ox, -un, ray_dx, den);
            s.y = place_axis(ray_oy, -un, ray_dy, den);
        end else begin
            s.hit = 1'b0;
            s.x = MISS_COORD;
            s.y = MISS_COORD;
        end
        return s;
    endfunction

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Sends one wall; the expectation is queued at the accepting edge. The
    // valid stays up after the transfer so that walls can follow back to
    // back; whoever pauses the sender lowers it first.
    task automatic send_wall(input t_wall w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            seg_ch.valid <= 1'b0;
            wait_cycles(gap);
        end
        seg_ch.valid  <= 1'b1;
        seg_ch.seg_ax <= w.ax;
        seg_ch.seg_ay <= w.ay;
        seg_ch.seg_bx <= w.bx;
        seg_ch.seg_by <= w.by;
        do @(posedge i_clk); while (!seg_ch.ready);
        strikes_due.push_back(predict_strike(w));
    endtask

    // Waits for the block to drain, including the divider pipeline.
    task automatic drain_block();
        seg_ch.valid <= 1'b0;
        while (strikes_due.size() != 0) @(posedge i_clk);
        wait_cycles(60);
    endtask

    task automatic write_ray(input t_cfg_idx idx, input logic [CW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: ray_ox = val;
            CFG_ORIGIN_Y: ray_oy = val;
            CFG_DIR_X:    ray_dx = val[DW-1:0];
            default:      ray_dy = val[DW-1:0];
        endcase
    endtask

    task automatic set_ray(input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
                           input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
        drain_block();
        write_ray(CFG_ORIGIN_X, ox);
        write_ray(CFG_ORIGIN_Y, oy);
        write_ray(CFG_DIR_X, CW'(dx));
        write_ray(CFG_DIR_Y, CW'(dy));
    endtask

    function automatic t_wall make_wall(input int ax, input int ay, input int bx, input int by);
        t_wall w;
        w.ax = CW'(ax); w.ay = CW'(ay); w.bx = CW'(bx); w.by = CW'(by);
        return w;
    endfunction

    function automatic logic signed [CW-1:0] any_coord();
        return CW'($urandom);
    endfunction

    function automatic logic signed [CW-1:0] near_coord();
        return CW'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    // A wall that straddles the ray a random distance ahead, so most
    // random walls actually produce a strike.
    function automatic t_wall crossing_wall();
        t_wall w;
        longint reach, side, px, py, nx, ny;
        reach = $urandom_range(1, 200000);
        side = $urandom_range(1, 100000);
        px = longint'(ray_ox) + (reach * ray_dx) / 16384;
        py = longint'(ray_oy) + (reach * ray_dy) / 16384;
        nx = -ray_dy; ny = ray_dx;
        w.ax = CW'(px + (side * nx) / 16384 + $signed($urandom_range(0, 64)) - 32);
        w.ay = CW'(py + (side * ny) / 16384 + $signed($urandom_range(0, 64)) - 32);
        w.bx = CW'(px - (side * nx) / 16384 + $signed($urandom_range(0, 64)) - 32);
        w.by = CW'(py - (side * ny) / 16384 + $signed($urandom_range(0, 64)) - 32);
        return w;
    endfunction

    // Result side: random stalls, with quiet stretches and a forced hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_ch.ready <= 1'b0;
        end else begin
            if (hit_ch.valid && hit_ch.ready) begin
                if (strikes_due.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time,
                             hit_ch.hit, hit_ch.hit_x, hit_ch.hit_y);
                    errors++;
                end else begin
                    t_strike s;
                    s = strikes_due.pop_front();
                    if (hit_ch.hit !== s.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, s.hit, hit_ch.hit);
                        errors++;
                    end
                    if (hit_ch.hit_x !== s.x) begin
                        $display("%0t: hit_x expected %0d actual %0d", $time, s.x, hit_ch.hit_x);
                        errors++;
                    end
                    if (hit_ch.hit_y !== s.y) begin
                        $display("%0t: hit_y expected %0d actual %0d", $time, s.y, hit_ch.hit_y);
                        errors++;
                    end
                end
            end
            hit_ch.ready <= !rx_hold && (rx_quiet || $urandom_range(0, 9) < 5);
        end
    end

    task automatic test_corners();
        t_wall w;
        set_ray(0, 0, 16384, 0);
        send_wall(make_wall(2560, 256, 2560, -256));       // plain hit ahead
        send_wall(make_wall(-2560, 256, -2560, -256));     // behind the origin
        send_wall(make_wall(256, 256, 2560, 256));         // parallel to the ray
        send_wall(make_wall(2560, 0, 2560, -256));         // touches endpoint A
        send_wall(make_wall(2560, 256, 2560, 0));          // touches endpoint B
        send_wall(make_wall(0, 256, 0, -256));             // passes the origin
        send_wall(make_wall(8388607, 8388607, 8388607, -8388608));
        send_wall(make_wall(-8388608, -8388608, -8388608, -8388608));
        send_wall(make_wall(8388607, -8388608, -8388608, 8388607));
        send_wall(make_wall(1000, 300, 1700, -123));       // rounding of offsets
        set_ray(0, 0, 0, 0);                               // zero direction
        send_wall(make_wall(2560, 256, 2560, -256));
        set_ray(8388607, -8388608, -16384, 16384);         // far corner ray
        send_wall(make_wall(-8388608, 8388607, 8388607, 8388607));
        send_wall(make_wall(-8388608, -8388608, -8388608, 8388607));
        set_ray(-8388608, 8388607, 16384, -16384);
        send_wall(make_wall(8388607, -8388608, -8388608, -8388608));
        set_ray(0, 0, 1, 16384);                           // near-vertical, far hit
        send_wall(make_wall(-8388608, 8388000, 8388607, 8388607));
        set_ray(100, -100, 3, -1);                         // short direction
        send_wall(make_wall(2000, 256, 2000, -2000));
        w = make_wall(0, 0, 0, 0);
        send_wall(w);                                      // degenerate wall
    endtask

    task automatic test_random_rays();
        int ph, n;
        for (ph = 0; ph < 8; ph++) begin
            set_ray(ph < 4 ? near_coord() : any_coord(), ph < 4 ? near_coord() : any_coord(),
                    DW'($signed($urandom_range(0, 32768)) - 16384),
                    DW'($signed($urandom_range(0, 32768)) - 16384));
            tx_quiet = (ph == 2);
            rx_quiet = (ph == 3);
            for (n = 0; n < 45; n++) begin
                case ($urandom_range(0, 9))
                    0: send_wall(make_wall(any_coord(), any_coord(), any_coord(), any_coord()));
                    1: send_wall(make_wall(near_coord(), near_coord(), near_coord(), near_coord()));
                    default: send_wall(crossing_wall());
                endcase
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // The output stalls for a long stretch while walls keep coming, so the
    // queue fills and the input is held off; then the sender pauses for a
    // full drain.
    task automatic test_backpressure();
        int n;
        set_ray(0, 0, 16384, 0);
        fork
            begin
                rx_hold = 1'b1;
                wait_cycles(200);
                rx_hold = 1'b0;
            end
            begin
                tx_quiet = 1'b1;
                for (n = 0; n < 40; n++) send_wall(crossing_wall());
                seg_ch.valid <= 1'b0;
                tx_quiet = 1'b0;
            end
        join
        while (strikes_due.size() != 0) @(posedge i_clk);
        for (n = 0; n < 10; n++) send_wall(crossing_wall());
    endtask

    initial begin
        ray_ox = 0; ray_oy = 0; ray_dx = 16384; ray_dy = 0;
        wait_cycles(2);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random_rays();
        test_backpressure();
        drain_block();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
